// ===== rtl/bpt_pkg.sv =====
// Package for the barycentric point-in-triangle block.
// Holds the fixed widths, pipeline latencies and register indexes.
// Used by bpt_mul, bpt_div and barycentric_point_in_triangle.
package bpt_pkg;

  // Coordinate and intermediate widths.
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 3;
  localparam int MUL_W    = 2 * DOT_W;
  localparam int NUM_W    = MUL_W + 2;

  // Weight format: signed, WEIGHT_INT_BITS integer bits, FRAC_BITS fraction bits.
  localparam int FRAC_BITS       = 16;
  localparam int WEIGHT_INT_BITS = 3;
  localparam int Q_BITS          = WEIGHT_INT_BITS + FRAC_BITS;
  localparam int WEIGHT_W        = Q_BITS + 1;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int LIMIT_W   = 32;
  localparam int MARGIN_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEGENERATE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE_MARGIN    = 1'b1;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = 32'd1;
  localparam logic [MARGIN_W-1:0]  MARGIN_RESET = 16'd0;

  // Latencies of the arithmetic units.
  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = Q_BITS + 3;

endpackage

// ===== rtl/bpt_mul.sv =====
// Two-stage signed multiplier built from four narrow partial products.
// Depends on bpt_pkg for DOT_W and MUL_W.
module bpt_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [bpt_pkg::DOT_W-1:0]   a,
  input  logic signed [bpt_pkg::DOT_W-1:0]   b,
  output logic signed [bpt_pkg::MUL_W-1:0]   p
);
  import bpt_pkg::*;

  localparam int LO_W = DOT_W / 2;
  localparam int HI_W = DOT_W - LO_W;
  localparam int PP_W = 2 * HI_W;

  logic signed [HI_W-1:0] a_hi, b_hi, a_lo, b_lo;
  logic signed [PP_W-1:0] pp_hh, pp_hl, pp_lh, pp_ll;

  // Split each operand into a signed upper part and an unsigned lower part.
  assign a_hi = a[DOT_W-1:LO_W];
  assign b_hi = b[DOT_W-1:LO_W];
  assign a_lo = {{(HI_W-LO_W){1'b0}}, a[LO_W-1:0]};
  assign b_lo = {{(HI_W-LO_W){1'b0}}, b[LO_W-1:0]};

  // First stage: partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a_hi * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_ll <= a_lo * b_lo;
    end
  end

  // Second stage: weighted sum of the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (MUL_W'(pp_hh) <<< (2 * LO_W)) + (MUL_W'(pp_hl) <<< LO_W)
         + (MUL_W'(pp_lh) <<< LO_W) + MUL_W'(pp_ll);
    end
  end

endmodule

// ===== rtl/bpt_div.sv =====
// Pipelined restoring divider that turns a signed numerator and a positive
// denominator into a saturated signed weight. Depends on bpt_pkg.
module bpt_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [bpt_pkg::NUM_W-1:0]     num,
  input  logic        [bpt_pkg::NUM_W-1:0]     den,
  output logic signed [bpt_pkg::WEIGHT_W-1:0]  weight
);
  import bpt_pkg::*;

  localparam int RW = NUM_W + FRAC_BITS + WEIGHT_INT_BITS;

  logic              neg_a;
  logic [NUM_W-1:0]  mag_a;
  logic [NUM_W-1:0]  den_a;

  logic [RW-1:0]     rem_s [Q_BITS+1];
  logic [NUM_W-1:0]  den_s [Q_BITS+1];
  logic [Q_BITS-1:0] quo_s [Q_BITS+1];
  logic              neg_s [Q_BITS+1];
  logic              ovf_s [Q_BITS+1];

  // Sign and magnitude of the numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= num[NUM_W-1];
      mag_a <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_a <= den;
    end
  end

  // Overflow when the magnitude reaches the top of the integer range.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_s[0] <= {{WEIGHT_INT_BITS{1'b0}}, mag_a} >= {den_a, {WEIGHT_INT_BITS{1'b0}}};
      rem_s[0] <= RW'(mag_a) << FRAC_BITS;
      den_s[0] <= den_a;
      quo_s[0] <= '0;
      neg_s[0] <= neg_a;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < Q_BITS; j++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(den_s[j]) << (Q_BITS - 1 - j);
    assign ge    = rem_s[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1] <= ge ? rem_s[j] - trial : rem_s[j];
        quo_s[j+1] <= {quo_s[j][Q_BITS-2:0], ge};
        den_s[j+1] <= den_s[j];
        neg_s[j+1] <= neg_s[j];
        ovf_s[j+1] <= ovf_s[j];
      end
    end
  end

  // Apply the sign and saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_s[Q_BITS]) begin
        weight <= neg_s[Q_BITS] ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, {Q_BITS{1'b1}}};
      end else if (neg_s[Q_BITS]) begin
        weight <= -$signed({1'b0, quo_s[Q_BITS]});
      end else begin
        weight <= $signed({1'b0, quo_s[Q_BITS]});
      end
    end
  end

endmodule

// ===== rtl/barycentric_point_in_triangle.sv =====
// Barycentric point-in-triangle test, fully pipelined.
// Path: stages 1-7, the 22-stage dividers, the final and output registers.
// Throughput: one beat per cycle while the skid is free; dividers set the depth.
// An output skid register keeps input open while one result waits.
// Synchronous reset clears all valid bits and loads the register defaults.
module barycentric_point_in_triangle (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_a_x,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_a_y,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_a_z,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_b_x,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_b_y,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_b_z,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_c_x,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_c_y,
  input  logic signed [bpt_pkg::COORD_W-1:0]    vertex_c_z,
  input  logic signed [bpt_pkg::COORD_W-1:0]    point_x,
  input  logic signed [bpt_pkg::COORD_W-1:0]    point_y,
  input  logic signed [bpt_pkg::COORD_W-1:0]    point_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  inside_res,
  output logic                                  degenerate,
  output logic signed [bpt_pkg::WEIGHT_W-1:0]   weight_a,
  output logic signed [bpt_pkg::WEIGHT_W-1:0]   weight_b,
  output logic signed [bpt_pkg::WEIGHT_W-1:0]   weight_c,
  input  logic                                  cfg_we,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bpt_pkg::CFG_W-1:0]             cfg_data
);
  import bpt_pkg::*;

  logic en;

  // Configuration registers.
  logic [LIMIT_W-1:0]  degenerate_limit;
  logic [MARGIN_W-1:0] inside_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate_limit <= LIMIT_RESET;
      inside_margin    <= MARGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGENERATE_LIMIT: degenerate_limit <= cfg_data[LIMIT_W-1:0];
        REG_INSIDE_MARGIN:    inside_margin    <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input coordinates gathered per axis.
  logic signed [COORD_W-1:0] va [3];
  logic signed [COORD_W-1:0] vb [3];
  logic signed [COORD_W-1:0] vc [3];
  logic signed [COORD_W-1:0] vp [3];

  assign va[0] = vertex_a_x;
  assign va[1] = vertex_a_y;
  assign va[2] = vertex_a_z;
  assign vb[0] = vertex_b_x;
  assign vb[1] = vertex_b_y;
  assign vb[2] = vertex_b_z;
  assign vc[0] = vertex_c_x;
  assign vc[1] = vertex_c_y;
  assign vc[2] = vertex_c_z;
  assign vp[0] = point_x;
  assign vp[1] = point_y;
  assign vp[2] = point_z;

  // Valid bits of the pipeline stages; dg carries the degenerate flag.
  logic v1, v2, v3, v6, v7;
  logic mv [MUL_LAT];
  logic dv [DIV_LAT];
  logic dg [DIV_LAT];
  logic pv;

  // Stage 1: edge vectors from vertex A.
  logic signed [DIFF_W-1:0] ab [3];
  logic signed [DIFF_W-1:0] ac [3];
  logic signed [DIFF_W-1:0] ap [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab[i] <= DIFF_W'(vb[i]) - DIFF_W'(va[i]);
        ac[i] <= DIFF_W'(vc[i]) - DIFF_W'(va[i]);
        ap[i] <= DIFF_W'(vp[i]) - DIFF_W'(va[i]);
      end
    end
  end

  // Stage 2: per-axis products for the five dot products.
  logic signed [PROD_W-1:0] p00 [3];
  logic signed [PROD_W-1:0] p01 [3];
  logic signed [PROD_W-1:0] p11 [3];
  logic signed [PROD_W-1:0] p20 [3];
  logic signed [PROD_W-1:0] p21 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p00[i] <= ab[i] * ab[i];
        p01[i] <= ab[i] * ac[i];
        p11[i] <= ac[i] * ac[i];
        p20[i] <= ap[i] * ab[i];
        p21[i] <= ap[i] * ac[i];
      end
    end
  end

  // Stage 3: dot products.
  logic signed [DOT_W-1:0] d00, d01, d11, d20, d21;

  always_ff @(posedge clk) begin
    if (en) begin
      d00 <= DOT_W'(p00[0]) + DOT_W'(p00[1]) + DOT_W'(p00[2]);
      d01 <= DOT_W'(p01[0]) + DOT_W'(p01[1]) + DOT_W'(p01[2]);
      d11 <= DOT_W'(p11[0]) + DOT_W'(p11[1]) + DOT_W'(p11[2]);
      d20 <= DOT_W'(p20[0]) + DOT_W'(p20[1]) + DOT_W'(p20[2]);
      d21 <= DOT_W'(p21[0]) + DOT_W'(p21[1]) + DOT_W'(p21[2]);
    end
  end

  // Stages 4 and 5: the six wide products.
  logic signed [MUL_W-1:0] m00_11, m01_01, m11_20, m01_21, m00_21, m01_20;

  bpt_mul u_mul_den_a (.clk(clk), .en(en), .a(d00), .b(d11), .p(m00_11));
  bpt_mul u_mul_den_b (.clk(clk), .en(en), .a(d01), .b(d01), .p(m01_01));
  bpt_mul u_mul_nb_a  (.clk(clk), .en(en), .a(d11), .b(d20), .p(m11_20));
  bpt_mul u_mul_nb_b  (.clk(clk), .en(en), .a(d01), .b(d21), .p(m01_21));
  bpt_mul u_mul_nc_a  (.clk(clk), .en(en), .a(d00), .b(d21), .p(m00_21));
  bpt_mul u_mul_nc_b  (.clk(clk), .en(en), .a(d01), .b(d20), .p(m01_20));

  // Stage 6: determinant and the numerators of B and C.
  logic signed [NUM_W-1:0] den6, nb6, nc6;

  always_ff @(posedge clk) begin
    if (en) begin
      den6 <= NUM_W'(m00_11) - NUM_W'(m01_01);
      nb6  <= NUM_W'(m11_20) - NUM_W'(m01_21);
      nc6  <= NUM_W'(m00_21) - NUM_W'(m01_20);
    end
  end

  // Stage 7: numerator of A and the degenerate test. The determinant is
  // never negative, so it compares as unsigned.
  logic signed [NUM_W-1:0] den7, na7, nb7, nc7;
  logic                    deg7;

  always_ff @(posedge clk) begin
    if (en) begin
      den7 <= den6;
      nb7  <= nb6;
      nc7  <= nc6;
      na7  <= den6 - nb6 - nc6;
      deg7 <= (den6 == '0) ||
              ($unsigned(den6) < {{(NUM_W-LIMIT_W){1'b0}}, degenerate_limit});
    end
  end

  // Divider pipelines, one per weight.
  logic signed [WEIGHT_W-1:0] wa_d, wb_d, wc_d;

  bpt_div u_div_a (.clk(clk), .en(en), .num(na7), .den($unsigned(den7)), .weight(wa_d));
  bpt_div u_div_b (.clk(clk), .en(en), .num(nb7), .den($unsigned(den7)), .weight(wb_d));
  bpt_div u_div_c (.clk(clk), .en(en), .num(nc7), .den($unsigned(den7)), .weight(wc_d));

  // Degenerate flag travels beside the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      dg[0] <= deg7;
      for (int i = 1; i < DIV_LAT; i++) begin
        dg[i] <= dg[i-1];
      end
    end
  end

  // Final stage: mask the weights and apply the inside test.
  logic                       p_inside, p_deg;
  logic signed [WEIGHT_W-1:0] p_wa, p_wb, p_wc;
  logic signed [WEIGHT_W:0]   lim;

  assign lim = -$signed({{(WEIGHT_W+1-MARGIN_W){1'b0}}, inside_margin});

  always_ff @(posedge clk) begin
    if (en) begin
      p_deg    <= dg[DIV_LAT-1];
      p_wa     <= dg[DIV_LAT-1] ? '0 : wa_d;
      p_wb     <= dg[DIV_LAT-1] ? '0 : wb_d;
      p_wc     <= dg[DIV_LAT-1] ? '0 : wc_d;
      p_inside <= !dg[DIV_LAT-1] && ((WEIGHT_W+1)'(wa_d) >= lim) &&
                  ((WEIGHT_W+1)'(wb_d) >= lim) && ((WEIGHT_W+1)'(wc_d) >= lim);
    end
  end

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      pv <= 1'b0;
      for (int i = 0; i < MUL_LAT; i++) mv[i] <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) dv[i] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      mv[0] <= v3;
      for (int i = 1; i < MUL_LAT; i++) mv[i] <= mv[i-1];
      v6    <= mv[MUL_LAT-1];
      v7    <= v6;
      dv[0] <= v7;
      for (int i = 1; i < DIV_LAT; i++) dv[i] <= dv[i-1];
      pv    <= dv[DIV_LAT-1];
    end
  end

  // Output register with one skid entry. The pipeline runs while the skid
  // entry is free; a result that meets a held output beat parks there.
  logic                       sv;
  logic                       s_inside, s_deg;
  logic signed [WEIGHT_W-1:0] s_wa, s_wb, s_wc;

  assign en       = !sv;
  assign in_ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sv        <= 1'b0;
    end else if (sv) begin
      if (out_ready) begin
        sv <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= pv;
    end else if (pv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (out_ready) begin
        inside_res <= s_inside;
        degenerate <= s_deg;
        weight_a   <= s_wa;
        weight_b   <= s_wb;
        weight_c   <= s_wc;
      end
    end else if (!out_valid || out_ready) begin
      inside_res <= p_inside;
      degenerate <= p_deg;
      weight_a   <= p_wa;
      weight_b   <= p_wb;
      weight_c   <= p_wc;
    end else begin
      s_inside <= p_inside;
      s_deg    <= p_deg;
      s_wa     <= p_wa;
      s_wb     <= p_wb;
      s_wc     <= p_wc;
    end
  end

  // The skid entry is only ever filled behind a held output beat.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    sv |-> out_valid) else $error("skid entry full without an output beat");

  // A drained skid entry becomes the next output beat.
  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    (sv && out_ready) |=> (out_valid && !sv))
    else $error("skid entry lost on drain");

  // A degenerate result carries zero weights and is never inside.
  a_degenerate_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |->
      (!inside_res && weight_a == '0 && weight_b == '0 && weight_c == '0))
    else $error("degenerate result with nonzero fields");

endmodule
